FILE: rtl/bgfc_pkg.sv
// shared types and constants of the four-colour backtracking search
package bgfc_pkg;

  localparam int unsigned MaxRegions  = 8;
  localparam int unsigned ColorCount  = 4;
  localparam int unsigned RowCount    = 8;
  localparam int unsigned VertexLimit = (MaxRegions < RowCount) ? MaxRegions : RowCount;

  localparam int unsigned IdxW   = $clog2(RowCount);
  localparam int unsigned DepthW = IdxW + 1;
  localparam int unsigned ColorW = 3;
  localparam int unsigned CountW = 4;

  typedef logic [RowCount-1:0] row_t;
  typedef row_t [RowCount-1:0] adj_rows_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPop,
    StEmit,
    StFail
  } search_state_e;

  typedef struct packed {
    logic [IdxW-1:0]   region;
    logic [ColorW-1:0] color;
    logic              found;
    logic              last;
  } result_t;

endpackage

FILE: rtl/backtracking_graph_four_coloring_unit.sv
// top level of the four-colour backtracking graph colourer
//
// Usage: write the eight adjacency rows through the cfg port (cfg_idx_i selects the row,
// bit k of row v set when v neighbours k), then send one start transfer on the slave
// stream with region_count in tdata[3:0]. Counts of 0 are taken as 1 and counts above
// 8 as 8. The block colours vertices 0..n-1 by depth-first backtracking and then sends
// n result transfers (region, colour, found=1, tlast on the final one) on the master
// stream, or a single transfer with colour 0, found 0 and tlast when no colouring exists.
// Each trial colour of vertex v is checked against vertices 0..v-1 one at a time in the
// single clash comparator; a clash moves on to the next colour, and when all four fail
// the search backtracks to the previous vertex. Each result passes the output register.
// s_axis_tready_o is high only while no search is running.
// The result register lets the next start be taken while the last result still waits.
// When the receiver stalls, results hold in the output register and the search waits.
// Reset clears the adjacency rows to zero and returns the block to idle.
module backtracking_graph_four_coloring_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [3:0] region_count, [7:4] zero
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [2:0] region, [5:3] color, [7:6] zero
  output logic       m_axis_tuser_o,   // [0] found
  output logic       m_axis_tlast_o
);
  import bgfc_pkg::*;

  adj_rows_t         adj_q;
  logic [DepthW-1:0] count;
  logic [CountW-1:0] count_raw;
  logic              idle;
  logic              start;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              out_valid_q;
  result_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0;
    end else if (cfg_we_i) begin
      adj_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign count_raw = s_axis_tdata_i[CountW-1:0];

  always_comb begin
    if (count_raw == '0) begin
      count = DepthW'(1);
    end else if (count_raw > CountW'(VertexLimit)) begin
      count = DepthW'(VertexLimit);
    end else begin
      count = DepthW'(count_raw);
    end
  end

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  assign res_ready       = !out_valid_q || m_axis_tready_i;

  bgfc_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .count_i     (count),
    .adj_i       (adj_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.color, out_q.region};
  assign m_axis_tuser_o  = out_q.found;
  assign m_axis_tlast_o  = out_q.last;

endmodule

FILE: rtl/bgfc_search.sv
// backtracking sequencer with colour stack and a single shared clash comparator
module bgfc_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bgfc_pkg::DepthW-1:0] count_i,
  input  bgfc_pkg::adj_rows_t      adj_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output bgfc_pkg::result_t        res_o
);
  import bgfc_pkg::*;

  search_state_e      state_q, state_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic [DepthW-1:0]  n_q, n_d;
  logic [ColorW-1:0]  trial_q, trial_d;
  logic [IdxW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [ColorW-1:0]  stack_q [RowCount];

  logic [IdxW-1:0]    rd_idx;
  logic [ColorW-1:0]  rd_color;
  logic [DepthW-1:0]  pop_depth;
  logic               clash;
  logic               stack_we;
  logic               emit_last;

  assign pop_depth = depth_q - DepthW'(1);

  always_comb begin
    case (state_q)
      StPop:   rd_idx = pop_depth[IdxW-1:0];
      StEmit:  rd_idx = idx_q;
      default: rd_idx = k_q;
    endcase
  end

  assign rd_color = stack_q[rd_idx];

  // shared compare unit: one earlier vertex per cycle
  assign clash = adj_i[depth_q[IdxW-1:0]][k_q] && (rd_color == trial_q);

  assign emit_last = ({1'b0, idx_q} + DepthW'(1)) == n_q;

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    n_d         = n_q;
    trial_d     = trial_q;
    k_d         = k_q;
    idx_d       = idx_q;
    stack_we    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = count_i;
          depth_d = '0;
          trial_d = ColorW'(1);
          k_d     = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if ({1'b0, k_q} == depth_q) begin
          stack_we = 1'b1;
          depth_d  = depth_q + DepthW'(1);
          trial_d  = ColorW'(1);
          k_d      = '0;
          if (depth_q + DepthW'(1) >= n_q) begin
            idx_d   = '0;
            state_d = StEmit;
          end
        end else if (clash) begin
          k_d = '0;
          if (trial_q == ColorW'(ColorCount)) begin
            state_d = (depth_q == '0) ? StFail : StPop;
          end else begin
            trial_d = trial_q + ColorW'(1);
          end
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      StPop: begin
        depth_d = pop_depth;
        k_d     = '0;
        if (rd_color == ColorW'(ColorCount)) begin
          if (pop_depth == '0) begin
            state_d = StFail;
          end
        end else begin
          trial_d = rd_color + ColorW'(1);
          state_d = StScan;
        end
      end
      StEmit: begin
        res_valid_o  = 1'b1;
        res_o.region = idx_q;
        res_o.color  = rd_color;
        res_o.found  = 1'b1;
        res_o.last   = emit_last;
        if (res_ready_i) begin
          idx_d = idx_q + IdxW'(1);
          if (emit_last) begin
            trial_d = ColorW'(1);
            state_d = StIdle;
          end
        end
      end
      StFail: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          depth_d = '0;
          trial_d = ColorW'(1);
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign idle_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      depth_q <= '0;
      n_q     <= DepthW'(1);
      trial_q <= ColorW'(1);
      k_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      n_q     <= n_d;
      trial_q <= trial_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_q[depth_q[IdxW-1:0]] <= trial_q;
    end
  end

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (depth_q <= n_q))
    else $error("stack depth above vertex count");

  a_trial_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (trial_q >= ColorW'(1) && trial_q <= ColorW'(ColorCount)))
    else $error("trial colour out of range during scan");

  a_scan_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ({1'b0, k_q} <= depth_q && depth_q < n_q))
    else $error("scan index past current vertex");

  a_push_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && stack_we) |=> (depth_q == $past(depth_q) + DepthW'(1)))
    else $error("push did not advance depth");

endmodule
